// ===== sv/tdpt_pkg.sv =====
// ----------------------------------------------------------------------------
// tdpt_pkg: shared types and control store for the trial-division prime test
// Holds the micro-op codes, the control word layout and the program ROM.
// ----------------------------------------------------------------------------
`default_nettype none

package tdpt_pkg;

    // Default width of the number under test
    localparam int NUMBER_WIDTH = 32;
    // Width of the candidate field on the input stream
    localparam int CAND_WIDTH   = 32;
    // Output tdata is one byte, is_prime in bit 0
    localparam int OUT_TDATA_W  = 8;
    // Program counter width (16-entry control store)
    localparam int PC_WIDTH     = 4;

    typedef logic [PC_WIDTH-1:0] pc_t;

    // Datapath actions
    typedef enum logic [3:0] {
        ACT_NONE      = 4'd0,
        ACT_LOAD      = 4'd1,  // input ready, latch candidate
        ACT_SET_D3    = 4'd2,  // first odd divisor
        ACT_DIV_START = 4'd3,  // load divider
        ACT_DIV_STEP  = 4'd4,  // one restoring division step
        ACT_INC_D     = 4'd5,  // next odd divisor
        ACT_RES0      = 4'd6,
        ACT_RES1      = 4'd7,
        ACT_EMIT      = 4'd8   // load output register
    } act_t;

    // Jump conditions; jump taken when true, else fall through
    typedef enum logic [3:0] {
        COND_NEVER    = 4'd0,
        COND_ALWAYS   = 4'd1,
        COND_NO_INPUT = 4'd2,
        COND_LT2      = 4'd3,
        COND_IS2      = 4'd4,
        COND_EVEN     = 4'd5,
        COND_DIV_MORE = 4'd6,
        COND_D_GT_Q   = 4'd7,
        COND_REM_ZERO = 4'd8,
        COND_OUT_FULL = 4'd9
    } cond_t;

    typedef struct packed {
        act_t  act;
        cond_t cond;
        pc_t   target;
    } ucw_t;

    // Program addresses
    localparam pc_t PC_ACCEPT    = 4'd0;
    localparam pc_t PC_LT2       = 4'd1;
    localparam pc_t PC_IS2       = 4'd2;
    localparam pc_t PC_EVEN      = 4'd3;
    localparam pc_t PC_SET_D3    = 4'd4;
    localparam pc_t PC_DIV_START = 4'd5;
    localparam pc_t PC_DIV_STEP  = 4'd6;
    localparam pc_t PC_CHK_Q     = 4'd7;
    localparam pc_t PC_CHK_REM   = 4'd8;
    localparam pc_t PC_NEXT_D    = 4'd9;
    localparam pc_t PC_RES0      = 4'd10;
    localparam pc_t PC_RES1      = 4'd11;
    localparam pc_t PC_OUT_WAIT  = 4'd12;
    localparam pc_t PC_EMIT      = 4'd13;

    // Control store
    function automatic ucw_t ucode_rom(input pc_t pc);
        ucw_t w;
        case (pc)
            PC_ACCEPT:    w = '{ACT_LOAD,      COND_NO_INPUT, PC_ACCEPT};
            PC_LT2:       w = '{ACT_NONE,      COND_LT2,      PC_RES0};
            PC_IS2:       w = '{ACT_NONE,      COND_IS2,      PC_RES1};
            PC_EVEN:      w = '{ACT_NONE,      COND_EVEN,     PC_RES0};
            PC_SET_D3:    w = '{ACT_SET_D3,    COND_NEVER,    PC_ACCEPT};
            PC_DIV_START: w = '{ACT_DIV_START, COND_NEVER,    PC_ACCEPT};
            PC_DIV_STEP:  w = '{ACT_DIV_STEP,  COND_DIV_MORE, PC_DIV_STEP};
            PC_CHK_Q:     w = '{ACT_NONE,      COND_D_GT_Q,   PC_RES1};
            PC_CHK_REM:   w = '{ACT_NONE,      COND_REM_ZERO, PC_RES0};
            PC_NEXT_D:    w = '{ACT_INC_D,     COND_ALWAYS,   PC_DIV_START};
            PC_RES0:      w = '{ACT_RES0,      COND_ALWAYS,   PC_OUT_WAIT};
            PC_RES1:      w = '{ACT_RES1,      COND_NEVER,    PC_ACCEPT};
            PC_OUT_WAIT:  w = '{ACT_NONE,      COND_OUT_FULL, PC_OUT_WAIT};
            PC_EMIT:      w = '{ACT_EMIT,      COND_ALWAYS,   PC_ACCEPT};
            default:      w = '{ACT_NONE,      COND_ALWAYS,   PC_ACCEPT};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== sv/trial_division_prime_test.sv =====
// ----------------------------------------------------------------------------
// trial_division_prime_test: primality test by trial division
// Microcoded sequencer over a one-bit-per-cycle restoring divider.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_tvalid/s_tready/s_tdata carries one candidate per item
//   (s_tdata[31:0]); only its low NUMBER_WIDTH bits are tested. Output stream
//   m_tvalid/m_tready/m_tdata returns one item per candidate, is_prime in
//   m_tdata[0], in input order.
//   One candidate is worked on at a time. Values below 2 and even values other
//   than 2 give is_prime 0, and 2 gives 1, without a division. Odd values try
//   odd divisors d = 3, 5, ... while d <= n / d; each trial is one pass of the
//   shared restoring divider. An odd prime n tries every odd d up to its root;
//   a composite stops at its smallest odd factor. s_tready for the next
//   candidate rises in the same cycle as m_tvalid.
//   The output register holds a finished result while the sequencer goes back
//   for the next candidate; if the receiver stalls, the sequencer waits only
//   when the following result is ready to be written.
//   Reset (rst_n low, asynchronous) returns the sequencer to the accept step
//   and empties the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module trial_division_prime_test #(
    parameter int NUMBER_WIDTH = tdpt_pkg::NUMBER_WIDTH
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [tdpt_pkg::CAND_WIDTH-1:0] s_tdata,   // [31:0] candidate
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [tdpt_pkg::OUT_TDATA_W-1:0]     m_tdata    // [0] is_prime, [7:1] zero
);

    localparam int W     = NUMBER_WIDTH;
    localparam int CNT_W = $clog2(W + 1);
    localparam int EXT_W = 64 + tdpt_pkg::CAND_WIDTH;

    // Sequencer and datapath registers
    tdpt_pkg::pc_t    pc_reg, pc_next;
    logic [W-1:0]     n_reg, n_next;
    logic [W-1:0]     d_reg, d_next;
    logic [W-1:0]     rem_reg, rem_next;
    logic [W-1:0]     quo_reg, quo_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             res_reg, res_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic             m_bit_reg, m_bit_next;

    tdpt_pkg::ucw_t   ucw;
    logic             cond_true;
    logic [EXT_W-1:0] cand_ext;
    logic [W:0]       trial;
    logic [W+1:0]     diff;
    logic             ge;

    assign ucw      = tdpt_pkg::ucode_rom(pc_reg);
    assign cand_ext = {{(EXT_W - tdpt_pkg::CAND_WIDTH){1'b0}}, s_tdata};

    // Divider step: shift in next dividend bit, subtract if it fits
    assign trial = {rem_reg, quo_reg[W-1]};
    assign diff  = {1'b0, trial} - {2'b00, d_reg};
    assign ge    = ~diff[W+1];

    // Condition select
    always_comb
    begin
        case (ucw.cond)
            tdpt_pkg::COND_NEVER:    cond_true = 1'b0;
            tdpt_pkg::COND_ALWAYS:   cond_true = 1'b1;
            tdpt_pkg::COND_NO_INPUT: cond_true = ~s_tvalid;
            tdpt_pkg::COND_LT2:      cond_true = (n_reg < W'(2));
            tdpt_pkg::COND_IS2:      cond_true = (n_reg == W'(2));
            tdpt_pkg::COND_EVEN:     cond_true = ~n_reg[0];
            tdpt_pkg::COND_DIV_MORE: cond_true = (cnt_reg != CNT_W'(1));
            tdpt_pkg::COND_D_GT_Q:   cond_true = (d_reg > quo_reg);
            tdpt_pkg::COND_REM_ZERO: cond_true = (rem_reg == '0);
            tdpt_pkg::COND_OUT_FULL: cond_true = m_tvalid_reg & ~m_tready;
            default:                 cond_true = 1'b0;
        endcase
    end

    assign pc_next = cond_true ? ucw.target : pc_reg + tdpt_pkg::pc_t'(1);

    // Datapath actions
    always_comb
    begin
        n_next        = n_reg;
        d_next        = d_reg;
        rem_next      = rem_reg;
        quo_next      = quo_reg;
        cnt_next      = cnt_reg;
        res_next      = res_reg;
        m_bit_next    = m_bit_reg;
        m_tvalid_next = m_tvalid_reg & ~m_tready;
        s_tready      = 1'b0;
        case (ucw.act)
            tdpt_pkg::ACT_LOAD:
            begin
                s_tready = 1'b1;
                n_next   = cand_ext[W-1:0];
            end
            tdpt_pkg::ACT_SET_D3:
            begin
                d_next = W'(3);
            end
            tdpt_pkg::ACT_DIV_START:
            begin
                rem_next = '0;
                quo_next = n_reg;
                cnt_next = CNT_W'(W);
            end
            tdpt_pkg::ACT_DIV_STEP:
            begin
                rem_next = ge ? diff[W-1:0] : trial[W-1:0];
                quo_next = {quo_reg[W-2:0], ge};
                cnt_next = cnt_reg - CNT_W'(1);
            end
            tdpt_pkg::ACT_INC_D:
            begin
                d_next = d_reg + W'(2);
            end
            tdpt_pkg::ACT_RES0:
            begin
                res_next = 1'b0;
            end
            tdpt_pkg::ACT_RES1:
            begin
                res_next = 1'b1;
            end
            tdpt_pkg::ACT_EMIT:
            begin
                m_tvalid_next = 1'b1;
                m_bit_next    = res_reg;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg       <= tdpt_pkg::PC_ACCEPT;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            pc_reg       <= pc_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        n_reg     <= n_next;
        d_reg     <= d_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        cnt_reg   <= cnt_next;
        res_reg   <= res_next;
        m_bit_reg <= m_bit_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(tdpt_pkg::OUT_TDATA_W - 1){1'b0}}, m_bit_reg};

endmodule

`default_nettype wire

// ===== tb/tb_trial_division_prime_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_trial_division_prime_test: self-checking bench for the prime tester
// Streams candidates into the block and checks every is_prime result, in
// order, against a trial-division predictor built into the bench. Both stream
// sides idle at random. One long receiver hold-off backs the block up.
// ----------------------------------------------------------------------------

module tb_trial_division_prime_test;

    localparam int NUMBER_WIDTH = tdpt_pkg::NUMBER_WIDTH;
    localparam int CAND_WIDTH   = tdpt_pkg::CAND_WIDTH;
    localparam int OUT_TDATA_W  = tdpt_pkg::OUT_TDATA_W;

    localparam int NUM_RANDOM   = 119;
    // Random candidates whose search would take more divisor trials are redrawn
    localparam int TRIAL_BUDGET = 200;
    localparam int HOLD_AFTER   = 30;     // results seen before the long hold-off
    localparam int HOLD_CYCLES  = 10000;
    localparam int DRAIN_CYCLES = 200;
    localparam int MAX_REPORTS  = 10;

    logic                   clk      = 1'b0;
    logic                   rst_n    = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [CAND_WIDTH-1:0]  s_tdata  = '0;    // [31:0] candidate
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;          // [0] is_prime, [7:1] zero

    logic [CAND_WIDTH-1:0]  pending_cands[$];
    bit                     verdict_q[$];
    int                     total_cands  = 0;
    int                     cands_sent   = 0;
    int                     results_seen = 0;
    int                     primes_seen  = 0;
    int                     errors       = 0;
    int                     hold_cnt     = 0;
    bit                     hold_done    = 1'b0;
    int                     held_in      = 0;  // cycles the input stalled in the hold-off
    int                     tx_idle      = 0;
    int                     tx_quiet     = 0;
    int                     rx_idle      = 0;
    int                     rx_quiet     = 0;

    trial_division_prime_test u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Trial division over odd divisors while d <= n / d; also returns the
    // number of divisions tried, which sets how long the block will take
    function automatic bit prime_verdict(input logic [CAND_WIDTH-1:0] cand,
                                         output int trials);
        longint unsigned n;
        longint unsigned d;
        n      = cand;
        trials = 0;
        if (NUMBER_WIDTH < 64)
            n = n & ((64'd1 << NUMBER_WIDTH) - 1);
        if (n < 2)
            return 1'b0;
        if (n[0] == 1'b0)
            return n == 2;
        for (d = 3; d <= n / d; d += 2)
        begin
            trials++;
            if (n % d == 0)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // Idle length: mostly none or short, a few long, with quiet stretches
    function automatic int idle_len(inout int quiet);
        int r;
        if (quiet > 0)
        begin
            quiet--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0)
        begin
            quiet = $urandom_range(8, 30);
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 15);
        return $urandom_range(20, 80);
    endfunction

    // Input driver: presents queued candidates, predicts on each accepted item
    always @(posedge clk or negedge rst_n)
    begin
        int trials;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                verdict_q.push_back(prime_verdict(s_tdata, trials));
                cands_sent <= cands_sent + 1;
            end
            if (!s_tvalid || s_tready)
            begin
                if (tx_idle > 0)
                begin
                    tx_idle--;
                    s_tvalid <= 1'b0;
                end
                else if (pending_cands.size() != 0)
                begin
                    s_tdata  <= pending_cands.pop_front();
                    s_tvalid <= 1'b1;
                    tx_idle  = idle_len(tx_quiet);
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off, started once enough results have come back
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_cnt  <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_cnt != 0)
        begin
            hold_cnt <= hold_cnt - 1;
            if (s_tvalid && !s_tready)
                held_in <= held_in + 1;
        end
        else if (!hold_done && results_seen >= HOLD_AFTER)
        begin
            hold_cnt  <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // Receiver ready with random stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_cnt != 0)
            m_tready <= 1'b0;
        else if (rx_idle > 0)
        begin
            rx_idle--;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
            if (m_tvalid && m_tready)
                rx_idle = idle_len(rx_quiet);
        end
    end

    // Result monitor: each result against the oldest prediction
    always @(posedge clk)
    begin
        logic [OUT_TDATA_W-1:0] want;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen <= results_seen + 1;
            if (m_tdata[0])
                primes_seen <= primes_seen + 1;
            if (verdict_q.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("ERROR: unexpected result %0h with nothing pending", m_tdata);
            end
            else
            begin
                want = OUT_TDATA_W'(verdict_q.pop_front());
                if (m_tdata !== want)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("ERROR: result %0d is_prime expected %0h got %0h",
                                 results_seen, want, m_tdata);
                end
            end
        end
    end

    // Stimulus and end of run
    initial
    begin
        logic [CAND_WIDTH-1:0] cand;
        int                    width;
        int                    trials;
        // Extremes, tiny values, squares of primes (divisor equals the root),
        // a large prime and a large square, all-ones and alternating patterns
        pending_cands = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd9, 32'd25,
                          32'd49, 32'd97, 32'd121, 32'd7919, 32'd65535, 32'd65537,
                          32'd16777213, 32'd16752649, 32'h8000_0000, 32'hFFFF_FFFE,
                          32'h5555_5555, 32'hAAAA_AAAA, 32'hFFFF_FFFF};
        // Random widths; early ones are short so the block runs fast into the hold-off
        for (int i = 0; i < NUM_RANDOM; i++)
        begin
            do
            begin
                width = (i < 12) ? $urandom_range(1, 8) : $urandom_range(1, CAND_WIDTH);
                cand  = $urandom;
                if (width < CAND_WIDTH)
                    cand = cand & ((CAND_WIDTH'(1) << width) - 1);
                if ($urandom_range(0, 1) == 1)
                    cand[width-1] = 1'b1;
                void'(prime_verdict(cand, trials));
            end
            while (trials > TRIAL_BUDGET);
            pending_cands.push_back(cand);
        end
        total_cands = pending_cands.size();

        repeat (4) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        while (cands_sent != total_cands)
            @(posedge clk);
        while (verdict_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Checked %0d results for %0d candidates, %0d of them prime",
                 results_seen, total_cands, primes_seen);
        $display("Receiver held off %0d cycles; input stalled %0d cycles meanwhile",
                 HOLD_CYCLES, held_in);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Watchdog, far beyond the slowest correct run
    initial
    begin
        #400_000_000;
        $display("Timeout waiting for results");
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== files.f =====
sv/tdpt_pkg.sv
sv/trial_division_prime_test.sv
tb/tb_trial_division_prime_test.sv
